[rtl/core/johnson_walk_loop_erasure_stats_unit_defines.svh]
// Assertion macros shared by the walk statistics RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef JOHNSON_WALK_LOOP_ERASURE_STATS_UNIT_DEFINES_SVH
`define JOHNSON_WALK_LOOP_ERASURE_STATS_UNIT_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define JWLE_ASSERT_IMPLY(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Condition a never holds.
`define JWLE_ASSERT_NEVER(lbl, a, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) else $error(msg);

`endif

[rtl/core/jwle_pkg.sv]
// Shared types, constants and helpers for the walk statistics unit.
// No dependencies.
package jwle_pkg;

  localparam int unsigned VB_MAX     = 16;  // widest vertex the helpers take
  localparam int unsigned EPOCH_BITS = 4;   // walk tag kept in each vertex table word
  localparam int unsigned PDATA_W    = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_DERIVE_UPPER = 1'b0;

  typedef struct packed {
    logic sweeping;
    logic idle;
  } jwle_stat_t;

  // Equal, or XOR has exactly two bits set
  function automatic logic jwle_adjacent(input logic [VB_MAX-1:0] a,
                                         input logic [VB_MAX-1:0] b);
    logic [VB_MAX-1:0] x;
    logic [4:0]        n;
    x = a ^ b;
    n = '0;
    for (int i = 0; i < VB_MAX; i++) begin
      n = n + 5'(x[i]);
    end
    return (x == '0) || (n == 5'd2);
  endfunction

endpackage

[rtl/core/jwle_front.sv]
// Front end: takes input transactions and forms the derived vertex.
// Depends on jwle_pkg; feeds jwle_queue.
module jwle_front #(
  parameter int unsigned VB = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          derive_upper,
  input  logic          hold,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [VB-1:0] in_vertex,
  input  logic          in_final_vertex,
  input  logic          q_full,
  output logic          q_push,
  output logic [VB+1:0] q_wdata
);
  import jwle_pkg::*;

  logic [VB-1:0] prev_r;
  logic          have_prev_r;
  logic          have_prev_nxt;
  logic [VB-1:0] derived;
  logic          acc;

  assign in_stall = q_full | hold;
  assign acc      = in_valid & ~in_stall;
  assign derived  = derive_upper ? (prev_r | in_vertex) : (prev_r & in_vertex);

  // entry: {has derived vertex, final, derived vertex}
  assign q_push  = acc;
  assign q_wdata = {have_prev_r, in_final_vertex, derived};

  always_comb begin
    have_prev_nxt = have_prev_r;
    if (acc) begin
      have_prev_nxt = ~in_final_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_r <= in_vertex;
    end
  end

endmodule

[rtl/core/jwle_queue.sv]
// Four-entry queue between the front end and the table engine.
// Depends on jwle_pkg.
module jwle_queue #(
  parameter int unsigned W = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import jwle_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  logic [W-1:0]  q_mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/jwle_back.sv]
// Table engine: seen map, stack positions, loop-erased stack, counters,
// and the result register. Depends on jwle_pkg; drains jwle_queue.
module jwle_back #(
  parameter int unsigned VB = 10,
  parameter int unsigned CB = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [VB+1:0]       q_rdata,
  output logic                q_pop,
  output jwle_pkg::jwle_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CB-1:0]       out_raw_length,
  output logic [CB-1:0]       out_compressed_length,
  output logic [CB-1:0]       out_distinct_count,
  output logic [CB-1:0]       out_compressed_bad_steps,
  output logic [CB-1:0]       out_loop_erased_length,
  output logic [CB-1:0]       out_first_visit_bad_steps
);
  import jwle_pkg::*;

  localparam int unsigned VCOUNT = 1 << VB;
  localparam int unsigned LW     = VB + 1;
  localparam int unsigned TW     = EPOCH_BITS;
  localparam int unsigned MW     = TW + 2 + VB;

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_POPRD = 6'b001000,
    ST_POPWR = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
    return (&c) ? c : c + CB'(1);
  endfunction

  // vertex table word: {walk tag, seen, on stack, stack position}
  logic [MW-1:0] vmem [VCOUNT];
  logic [VB-1:0] smem [VCOUNT];
  logic [MW-1:0] vm_rdata;
  logic [VB-1:0] sm_rdata;
  logic          vm_we, sm_we;
  logic [VB-1:0] vm_waddr, vm_raddr, sm_waddr, sm_raddr;
  logic [MW-1:0] vm_wdata;
  logic [VB-1:0] sm_wdata;

  state_t        state_r, state_nxt;
  logic [VB-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [TW-1:0] epoch_r, epoch_nxt;
  logic [VB-1:0] d_r, d_nxt;
  logic          fin_r, fin_nxt;
  logic [LW-1:0] keep_r, keep_nxt;
  logic [LW-1:0] stack_len_r, stack_len_nxt;
  logic [VB-1:0] last_comp_r, last_comp_nxt;
  logic          have_comp_r, have_comp_nxt;
  logic [VB-1:0] last_fv_r, last_fv_nxt;
  logic          have_fv_r, have_fv_nxt;
  logic [CB-1:0] raw_r, raw_nxt;
  logic [CB-1:0] comp_r, comp_nxt;
  logic [CB-1:0] dist_r, dist_nxt;
  logic [CB-1:0] bad_r, bad_nxt;
  logic [CB-1:0] fbad_r, fbad_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;
  logic [CB-1:0] le_sat;

  logic          live, seen, on_stack;
  logic [VB-1:0] pos;
  logic [LW-1:0] len_m1;
  logic          out_free;
  logic [32:0]   len_ext, cmax_ext;

  // entries written in an older walk read as cleared
  assign live     = (vm_rdata[MW-1 -: TW] == epoch_r);
  assign seen     = live & vm_rdata[VB+1];
  assign on_stack = live & vm_rdata[VB];
  assign pos      = vm_rdata[VB-1:0];
  assign len_m1   = stack_len_r - LW'(1);
  assign out_free = ~out_valid_r | ~out_stall;

  assign len_ext  = 33'(stack_len_r);
  assign cmax_ext = (33'(1) << CB) - 33'(1);
  assign le_sat   = (len_ext > cmax_ext) ? '1 : CB'(stack_len_r);

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    epoch_nxt     = epoch_r;
    d_nxt         = d_r;
    fin_nxt       = fin_r;
    keep_nxt      = keep_r;
    stack_len_nxt = stack_len_r;
    last_comp_nxt = last_comp_r;
    have_comp_nxt = have_comp_r;
    last_fv_nxt   = last_fv_r;
    have_fv_nxt   = have_fv_r;
    raw_nxt       = raw_r;
    comp_nxt      = comp_r;
    dist_nxt      = dist_r;
    bad_nxt       = bad_r;
    fbad_nxt      = fbad_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_load      = 1'b0;
    q_pop         = 1'b0;
    vm_we         = 1'b0;
    vm_waddr      = d_r;
    vm_wdata      = '0;
    vm_raddr      = q_rdata[VB-1:0];
    sm_we         = 1'b0;
    sm_waddr      = stack_len_r[VB-1:0];
    sm_wdata      = d_r;
    sm_raddr      = len_m1[VB-1:0];

    case (state_r)
      ST_SWEEP: begin
        vm_we         = 1'b1;
        vm_waddr      = sweep_cnt_r;
        sweep_cnt_nxt = sweep_cnt_r + VB'(1);
        if (&sweep_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_rdata[VB+1]) begin
            d_nxt     = q_rdata[VB-1:0];
            fin_nxt   = q_rdata[VB];
            state_nxt = ST_UPD;
          end else if (q_rdata[VB]) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_UPD: begin
        raw_nxt   = sat_inc(raw_r);
        state_nxt = fin_r ? ST_FIN : ST_IDLE;
        if (!seen) begin
          dist_nxt = sat_inc(dist_r);
          if (have_fv_r && !jwle_adjacent(VB_MAX'(last_fv_r), VB_MAX'(d_r))) begin
            fbad_nxt = sat_inc(fbad_r);
          end
          last_fv_nxt = d_r;
          have_fv_nxt = 1'b1;
        end
        vm_we    = 1'b1;
        vm_wdata = {epoch_r, 1'b1, on_stack, on_stack ? pos : VB'(0)};
        if (!(have_comp_r && (last_comp_r == d_r))) begin
          comp_nxt = sat_inc(comp_r);
          if (have_comp_r && !jwle_adjacent(VB_MAX'(last_comp_r), VB_MAX'(d_r))) begin
            bad_nxt = sat_inc(bad_r);
          end
          last_comp_nxt = d_r;
          have_comp_nxt = 1'b1;
          if (!on_stack) begin
            if (!stack_len_r[VB]) begin
              vm_wdata      = {epoch_r, 1'b1, 1'b1, stack_len_r[VB-1:0]};
              sm_we         = 1'b1;
              stack_len_nxt = stack_len_r + LW'(1);
            end
          end else begin
            // revisit: erase the loop above this vertex
            keep_nxt = {1'b0, pos} + LW'(1);
            if (stack_len_r > ({1'b0, pos} + LW'(1))) begin
              state_nxt = ST_POPRD;
            end
          end
        end
      end
      ST_POPRD: begin
        state_nxt = ST_POPWR;
      end
      ST_POPWR: begin
        vm_we         = 1'b1;
        vm_waddr      = sm_rdata;
        vm_wdata      = {epoch_r, 1'b1, 1'b0, VB'(0)};
        stack_len_nxt = len_m1;
        if (len_m1 > keep_r) begin
          state_nxt = ST_POPRD;
        end else begin
          state_nxt = fin_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          fin_nxt       = 1'b0;
          stack_len_nxt = '0;
          have_comp_nxt = 1'b0;
          have_fv_nxt   = 1'b0;
          raw_nxt       = '0;
          comp_nxt      = '0;
          dist_nxt      = '0;
          bad_nxt       = '0;
          fbad_nxt      = '0;
          if (&epoch_r) begin
            // tags are about to repeat: wipe the vertex table
            epoch_nxt     = TW'(1);
            sweep_cnt_nxt = '0;
            state_nxt     = ST_SWEEP;
          end else begin
            epoch_nxt = epoch_r + TW'(1);
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        sweep_cnt_nxt = '0;
        state_nxt     = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      epoch_r     <= TW'(1);
      fin_r       <= 1'b0;
      stack_len_r <= '0;
      have_comp_r <= 1'b0;
      have_fv_r   <= 1'b0;
      raw_r       <= '0;
      comp_r      <= '0;
      dist_r      <= '0;
      bad_r       <= '0;
      fbad_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      epoch_r     <= epoch_nxt;
      fin_r       <= fin_nxt;
      stack_len_r <= stack_len_nxt;
      have_comp_r <= have_comp_nxt;
      have_fv_r   <= have_fv_nxt;
      raw_r       <= raw_nxt;
      comp_r      <= comp_nxt;
      dist_r      <= dist_nxt;
      bad_r       <= bad_nxt;
      fbad_r      <= fbad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    keep_r      <= keep_nxt;
    last_comp_r <= last_comp_nxt;
    last_fv_r   <= last_fv_nxt;
    if (out_load) begin
      out_raw_length            <= raw_r;
      out_compressed_length     <= comp_r;
      out_distinct_count        <= dist_r;
      out_compressed_bad_steps  <= bad_r;
      out_loop_erased_length    <= le_sat;
      out_first_visit_bad_steps <= fbad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    vm_rdata <= vmem[vm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[sm_waddr] <= sm_wdata;
    end
    sm_rdata <= smem[sm_raddr];
  end

  assign out_valid     = out_valid_r;
  assign stat.sweeping = (state_r == ST_SWEEP);
  assign stat.idle     = (state_r == ST_IDLE);

endmodule

[rtl/core/johnson_walk_loop_erasure_stats_unit.sv]
// Walk statistics unit. Input channel (in_valid/in_stall) takes one walk
// vertex per transaction; in_final_vertex marks the last vertex of a walk.
// Each pair of consecutive vertices yields a derived vertex (AND, or OR when
// derive_upper is set through the APB port at byte address 0). The output
// channel (out_valid/out_stall) carries one transaction per walk, on its
// final vertex, with six saturating counts.
// Steps: the table engine reads the vertex table as it pops a derived
// vertex and writes it back in the update state; each stack pop reads the
// stack, then writes the vertex table. A vertex that derives nothing only
// leaves the queue, and the result is posted from a state of its own. Pops
// are at most the pushes. The engine takes no new vertex until the last one is through.
// A four-entry queue lets the input side run ahead of the table engine.
// After reset, and after every 15th walk, the vertex table is wiped word by
// word while in_stall is high; APB writes still land.
// While out_stall is high the result stays in the output register and the
// engine keeps working until it has the next result ready.
// Depends on jwle_pkg, jwle_front, jwle_queue, jwle_back.
`include "johnson_walk_loop_erasure_stats_unit_defines.svh"

module johnson_walk_loop_erasure_stats_unit #(
  parameter int unsigned VERTEX_BITS = 10,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [jwle_pkg::PDATA_W-1:0] pwdata,
  output logic [jwle_pkg::PDATA_W-1:0] prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VERTEX_BITS-1:0] in_vertex,
  input  logic                   in_final_vertex,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_BITS-1:0]  out_raw_length,
  output logic [COUNT_BITS-1:0]  out_compressed_length,
  output logic [COUNT_BITS-1:0]  out_distinct_count,
  output logic [COUNT_BITS-1:0]  out_compressed_bad_steps,
  output logic [COUNT_BITS-1:0]  out_loop_erased_length,
  output logic [COUNT_BITS-1:0]  out_first_visit_bad_steps
);
  import jwle_pkg::*;

  localparam int unsigned QW = VERTEX_BITS + 2;

  logic          derive_upper_r, derive_upper_nxt;
  logic          cfg_wr;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  jwle_stat_t    stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    derive_upper_nxt = derive_upper_r;
    if (cfg_wr && (paddr[2] == REG_DERIVE_UPPER)) begin
      derive_upper_nxt = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DERIVE_UPPER) begin
      prdata = PDATA_W'(derive_upper_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      derive_upper_r <= 1'b0;
    end else begin
      derive_upper_r <= derive_upper_nxt;
    end
  end

  jwle_front #(.VB(VERTEX_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .derive_upper    (derive_upper_r),
    .hold            (stat.sweeping),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex       (in_vertex),
    .in_final_vertex (in_final_vertex),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  jwle_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  jwle_back #(.VB(VERTEX_BITS), .CB(COUNT_BITS)) u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .q_empty                   (q_empty),
    .q_rdata                   (q_rdata),
    .q_pop                     (q_pop),
    .stat                      (stat),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_raw_length            (out_raw_length),
    .out_compressed_length     (out_compressed_length),
    .out_distinct_count        (out_distinct_count),
    .out_compressed_bad_steps  (out_compressed_bad_steps),
    .out_loop_erased_length    (out_loop_erased_length),
    .out_first_visit_bad_steps (out_first_visit_bad_steps)
  );

  `JWLE_ASSERT_IMPLY(a_push_room, q_push, !q_full, "queue push while full")
  `JWLE_ASSERT_IMPLY(a_pop_data, q_pop, !q_empty, "queue pop while empty")
  `JWLE_ASSERT_IMPLY(a_pop_idle, q_pop, stat.idle, "queue pop outside idle")
  `JWLE_ASSERT_NEVER(a_sweep_quiet, stat.sweeping && (q_pop || q_push), "traffic during wipe")

endmodule

[dv/walk_stats_checker.sv]
// Scoreboard for the walk statistics unit: mirrors the derived-walk counters and
// the loop-erased stack, and checks every result transaction in order.
// Depends on jwle_pkg for the register index and the APB data width.
module walk_stats_checker #(
  parameter int unsigned VERTEX_BITS = 10,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [jwle_pkg::PDATA_W-1:0]  pwdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [VERTEX_BITS-1:0]        in_vertex,
  input  logic                          in_final_vertex,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [COUNT_BITS-1:0]         out_raw_length,
  input  logic [COUNT_BITS-1:0]         out_compressed_length,
  input  logic [COUNT_BITS-1:0]         out_distinct_count,
  input  logic [COUNT_BITS-1:0]         out_compressed_bad_steps,
  input  logic [COUNT_BITS-1:0]         out_loop_erased_length,
  input  logic [COUNT_BITS-1:0]         out_first_visit_bad_steps,
  output int                            fail_count,
  output int                            pending_results
);

  localparam int VCOUNT      = 1 << VERTEX_BITS;
  localparam int STAT_FIELDS = 6;
  localparam int MAX_REPORTS = 10;

  localparam int F_RAW        = 0;
  localparam int F_COMPRESSED = 1;
  localparam int F_DISTINCT   = 2;
  localparam int F_COMP_BAD   = 3;
  localparam int F_ERASED     = 4;
  localparam int F_FV_BAD     = 5;

  typedef logic [VERTEX_BITS-1:0] vtx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STAT_FIELDS-1:0][COUNT_BITS-1:0] walk_stats_t;

  logic   derive_or;
  vtx_t   prev_vertex;
  logic   have_prev;
  vtx_t   last_comp;
  logic   have_comp;
  vtx_t   last_first;
  logic   have_first;
  logic   seen[VCOUNT];
  logic   on_stack[VCOUNT];
  int     stack_pos[VCOUNT];
  vtx_t   erased[VCOUNT];
  int     stack_len;
  count_t raw_len;
  count_t comp_len;
  count_t distinct;
  count_t comp_bad;
  count_t fv_bad;
  int     results_seen;

  walk_stats_t expected_stats[$];

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int ones_in(input vtx_t x);
    int n;
    n = 0;
    for (int i = 0; i < VERTEX_BITS; i++) n += x[i];
    return n;
  endfunction

  function automatic logic johnson_adj(input vtx_t a, input vtx_t b);
    return (a == b) || (ones_in(a ^ b) == 2);
  endfunction

  function void clear_walk();
    prev_vertex = '0;
    have_prev   = 1'b0;
    last_comp   = '0;
    have_comp   = 1'b0;
    last_first  = '0;
    have_first  = 1'b0;
    for (int i = 0; i < VCOUNT; i++) begin
      seen[i]      = 1'b0;
      on_stack[i]  = 1'b0;
      stack_pos[i] = 0;
      erased[i]    = '0;
    end
    stack_len = 0;
    raw_len   = '0;
    comp_len  = '0;
    distinct  = '0;
    comp_bad  = '0;
    fv_bad    = '0;
  endfunction

  function void absorb_derived(input vtx_t d);
    int   keep;
    vtx_t top;
    raw_len = sat_inc(raw_len);
    if (!seen[d]) begin
      seen[d]  = 1'b1;
      distinct = sat_inc(distinct);
      if (have_first && !johnson_adj(last_first, d)) fv_bad = sat_inc(fv_bad);
      last_first = d;
      have_first = 1'b1;
    end
    // repeated vertex collapses into the previous compressed step
    if (have_comp && last_comp == d) return;
    comp_len = sat_inc(comp_len);
    if (have_comp && !johnson_adj(last_comp, d)) comp_bad = sat_inc(comp_bad);
    last_comp = d;
    have_comp = 1'b1;
    if (!on_stack[d]) begin
      if (stack_len < VCOUNT) begin
        on_stack[d]       = 1'b1;
        stack_pos[d]      = stack_len;
        erased[stack_len] = d;
        stack_len++;
      end
    end else begin
      // revisit: erase the loop back down to the earlier occurrence
      keep = stack_pos[d] + 1;
      while (stack_len > keep) begin
        top            = erased[stack_len - 1];
        on_stack[top]  = 1'b0;
        stack_pos[top] = 0;
        stack_len--;
      end
    end
  endfunction

  function void predict_vertex(input vtx_t v, input logic fin);
    walk_stats_t res;
    if (have_prev) absorb_derived(derive_or ? (prev_vertex | v) : (prev_vertex & v));
    prev_vertex = v;
    have_prev   = 1'b1;
    if (fin) begin
      res[F_RAW]        = raw_len;
      res[F_COMPRESSED] = comp_len;
      res[F_DISTINCT]   = distinct;
      res[F_COMP_BAD]   = comp_bad;
      res[F_ERASED]     = (longint'(stack_len) > longint'(count_t'('1))) ? '1
                                                                        : count_t'(stack_len);
      res[F_FV_BAD]     = fv_bad;
      expected_stats.insert(expected_stats.size(), res);
      clear_walk();
    end
  endfunction

  function automatic string field_name(input int f);
    case (f)
      F_RAW:        return "raw_length";
      F_COMPRESSED: return "compressed_length";
      F_DISTINCT:   return "distinct_count";
      F_COMP_BAD:   return "compressed_bad_steps";
      F_ERASED:     return "loop_erased_length";
      default:      return "first_visit_bad_steps";
    endcase
  endfunction

  function void log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: result %0d: %s", $time, results_seen, msg);
  endfunction

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_seen    = 0;
    derive_or       = 1'b0;
    clear_walk();
  end

  always @(posedge clk) begin : monitor
    walk_stats_t got;
    walk_stats_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_first_visit_bad_steps, out_loop_erased_length, out_compressed_bad_steps,
               out_distinct_count, out_compressed_length, out_raw_length};
        if (expected_stats.size() == 0) begin
          log_failure("result transaction with no walk outstanding");
        end else begin
          want = expected_stats.pop_front();
          for (int f = 0; f < STAT_FIELDS; f++) begin
            if (got[f] !== want[f])
              log_failure($sformatf("%s expected %0d, got %0d", field_name(f), want[f], got[f]));
          end
        end
        results_seen++;
      end
      if (psel && penable && pwrite && pready && paddr[2] == jwle_pkg::REG_DERIVE_UPPER)
        derive_or = pwdata[0];
      if (in_valid && !in_stall) predict_vertex(in_vertex, in_final_vertex);
    end
    pending_results <= expected_stats.size();
  end

endmodule

[dv/tb_johnson_walk_loop_erasure_stats_unit.sv]
// Testbench top for the walk statistics unit: clock, reset, APB register writes,
// walk stimulus with random gaps and result backpressure, and the verdict.
// Depends on jwle_pkg, the unit itself and walk_stats_checker.
module tb_johnson_walk_loop_erasure_stats_unit;

  localparam int VERTEX_BITS   = 10;
  localparam int COUNT_BITS    = 20;
  localparam int VMAX          = (1 << VERTEX_BITS) - 1;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_PHASE    = 2;
  localparam int LONG_PHASE    = 5;
  localparam int LONG_WALK     = 400;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 64;
  localparam int LIMIT_CYCLES  = 1500000;

  typedef logic [VERTEX_BITS-1:0] vtx_t;
  typedef logic [jwle_pkg::PDATA_W-1:0] pdata_t;
  typedef enum int {WALK_JOHNSON, WALK_SUBSET, WALK_FULL, WALK_EXTREME} walk_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  pdata_t                pwdata;
  pdata_t                prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  vtx_t                  in_vertex;
  logic                  in_final_vertex;
  logic                  out_valid;
  logic                  out_stall;
  logic [COUNT_BITS-1:0] out_raw_length;
  logic [COUNT_BITS-1:0] out_compressed_length;
  logic [COUNT_BITS-1:0] out_distinct_count;
  logic [COUNT_BITS-1:0] out_compressed_bad_steps;
  logic [COUNT_BITS-1:0] out_loop_erased_length;
  logic [COUNT_BITS-1:0] out_first_visit_bad_steps;
  int                    fail_count;
  int                    pending_results;

  int   items_sent;
  bit   no_gaps;
  bit   hold_req;

  johnson_walk_loop_erasure_stats_unit #(
    .VERTEX_BITS(VERTEX_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_vertex                (in_vertex),
    .in_final_vertex          (in_final_vertex),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_raw_length           (out_raw_length),
    .out_compressed_length    (out_compressed_length),
    .out_distinct_count       (out_distinct_count),
    .out_compressed_bad_steps (out_compressed_bad_steps),
    .out_loop_erased_length   (out_loop_erased_length),
    .out_first_visit_bad_steps(out_first_visit_bad_steps)
  );

  walk_stats_checker #(
    .VERTEX_BITS(VERTEX_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) walk_check (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .pready                   (pready),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_vertex                (in_vertex),
    .in_final_vertex          (in_final_vertex),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_raw_length           (out_raw_length),
    .out_compressed_length    (out_compressed_length),
    .out_distinct_count       (out_distinct_count),
    .out_compressed_bad_steps (out_compressed_bad_steps),
    .out_loop_erased_length   (out_loop_erased_length),
    .out_first_visit_bad_steps(out_first_visit_bad_steps),
    .fail_count               (fail_count),
    .pending_results          (pending_results)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int input_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int pick_walk_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(1, 2);
    if (r < 80) return $urandom_range(3, 16);
    return $urandom_range(17, 80);
  endfunction

  // swap one bit in for one bit out within the bit range, else flip one bit
  function automatic vtx_t johnson_move(input vtx_t v, input vtx_t umask);
    int set_bits[VERTEX_BITS];
    int clr_bits[VERTEX_BITS];
    int n_set;
    int n_clr;
    n_set = 0;
    n_clr = 0;
    for (int i = 0; i < VERTEX_BITS; i++) begin
      if (umask[i]) begin
        if (v[i]) begin
          set_bits[n_set] = i;
          n_set++;
        end else begin
          clr_bits[n_clr] = i;
          n_clr++;
        end
      end
    end
    if (n_set > 0 && n_clr > 0) begin
      v[set_bits[$urandom_range(0, n_set - 1)]] = 1'b0;
      v[clr_bits[$urandom_range(0, n_clr - 1)]] = 1'b1;
    end else if (n_clr > 0) begin
      v[clr_bits[$urandom_range(0, n_clr - 1)]] = 1'b1;
    end else if (n_set > 0) begin
      v[set_bits[$urandom_range(0, n_set - 1)]] = 1'b0;
    end
    return v;
  endfunction

  function automatic vtx_t extreme_vertex();
    vtx_t one_hot;
    one_hot = '0;
    one_hot[$urandom_range(0, VERTEX_BITS - 1)] = 1'b1;
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return one_hot;
      default: return ~one_hot;
    endcase
  endfunction

  task automatic apb_write(input logic value);
    pdata_t wdata;
    wdata    = $urandom;
    wdata[0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {jwle_pkg::REG_DERIVE_UPPER, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_vertex(input vtx_t v, input logic fin);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_vertex       <= v;
    in_final_vertex <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait for every outstanding result, then let the table engine go quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_walk(input walk_kind_t kind, input int len, input int nb);
    vtx_t umask;
    vtx_t v;
    umask = '0;
    for (int i = 0; i < nb; i++) umask[i] = 1'b1;
    if ($urandom_range(0, 1)) umask = umask << $urandom_range(0, VERTEX_BITS - nb);
    v = vtx_t'($urandom_range(0, VMAX));
    if (kind == WALK_EXTREME) v = extreme_vertex();
    else if (kind != WALK_FULL) v = v & umask;
    for (int i = 0; i < len; i++) begin
      send_vertex(v, i == len - 1);
      case (kind)
        WALK_JOHNSON: if ($urandom_range(0, 99) >= 15) v = johnson_move(v, umask);
        WALK_SUBSET:  v = vtx_t'($urandom_range(0, VMAX)) & umask;
        WALK_FULL:    v = vtx_t'($urandom_range(0, VMAX));
        default:      v = extreme_vertex();
      endcase
    end
  endtask

  task automatic send_random_walk(input int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) send_walk(WALK_JOHNSON, len, $urandom_range(3, VERTEX_BITS));
    else if (r < 75) send_walk(WALK_SUBSET, len, $urandom_range(2, 4));
    else if (r < 90) send_walk(WALK_FULL, len, VERTEX_BITS);
    else send_walk(WALK_EXTREME, len, VERTEX_BITS);
  endtask

  // result-side backpressure; one long hold when the stimulus asks for it
  initial begin : result_backpressure
    int  r;
    int  span;
    bit  held_long;
    out_stall = 1'b0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held_long) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 4);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          span = $urandom_range(50, 150);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(10, 40);
        end
        repeat (span - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int random_start;
    int phase;
    int walks;
    int w;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    in_vertex       = '0;
    in_final_vertex = 1'b0;
    items_sent      = 0;
    no_gaps         = 1'b0;
    hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    apb_write(1'b0);

    // single-vertex walk derives nothing
    send_vertex('1, 1'b1);
    // lower walk over the extremes
    send_vertex('1, 1'b0);
    send_vertex('1, 1'b0);
    send_vertex('0, 1'b0);
    send_vertex('1, 1'b0);
    send_vertex(10'h003, 1'b0);
    send_vertex(10'h005, 1'b0);
    send_vertex(10'h006, 1'b1);
    // switch to the upper walk partway through a walk
    send_vertex(10'h0F0, 1'b0);
    send_vertex(10'h0F0, 1'b0);
    send_vertex(10'h3C0, 1'b0);
    drain_and_settle();
    apb_write(1'b1);
    send_vertex(10'h0C3, 1'b0);
    send_vertex('1, 1'b0);
    send_vertex('0, 1'b1);
    // upper walk that keeps returning to earlier vertices, forcing stack pops
    send_vertex(10'h001, 1'b0);
    send_vertex(10'h002, 1'b0);
    send_vertex(10'h001, 1'b0);
    send_vertex(10'h002, 1'b0);
    send_vertex(10'h004, 1'b0);
    send_vertex(10'h001, 1'b0);
    send_vertex(10'h003, 1'b1);
    send_vertex(10'h155, 1'b0);
    send_vertex(10'h2AA, 1'b1);
    drain_and_settle();

    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      apb_write(logic'(phase % 2) ^ ($urandom_range(0, 3) == 0));
      no_gaps = ($urandom_range(0, 4) == 0);
      if (phase == HOLD_PHASE) begin
        // short walks against a stalled result side fill the block up
        hold_req <= 1'b1;
        for (w = 0; w < 30; w++) send_random_walk($urandom_range(1, 3));
      end else if (phase == LONG_PHASE) begin
        send_walk(WALK_JOHNSON, LONG_WALK, VERTEX_BITS);
      end else begin
        walks = $urandom_range(1, 10);
        for (w = 0; w < walks; w++) send_random_walk(pick_walk_len());
      end
      drain_and_settle();
      phase++;
    end

    w = 0;
    do begin
      @(posedge clk);
      w++;
    end while (pending_results != 0 && w < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
